// ===== src/crc32bs_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32bs_pkg: shared definitions for the byte stream CRC-32 generator
// Polynomial, the single byte update function and the control bundle that
// travels from the stream front end to the CRC register.
// ----------------------------------------------------------------------------
package crc32bs_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 32;

  localparam logic [CrcW-1:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] CrcInit = '0;

  typedef struct packed {
    logic             en;    // absorb the byte this cycle
    logic             last;  // byte closes the message
    logic [ByteW-1:0] data;
  } crc32bs_step_t;

  // Eight LSB-first steps of the Galois shift register, unrolled into combinational logic.
  function automatic logic [CrcW-1:0] absorb_byte(input logic [CrcW-1:0] crc,
                                                  input logic [ByteW-1:0] data);
    logic [CrcW-1:0] r;
    logic            fb;
    r = crc;
    for (int k = 0; k < ByteW; k++) begin
      fb = data[k] ^ r[CrcW-1];
      r  = {r[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    return r;
  endfunction

endpackage

// ===== src/crc32bs_core.sv =====
// ----------------------------------------------------------------------------
// crc32bs_core: CRC-32 shift register
// Absorbs one byte per enabled cycle and clears itself after a closing byte.
// The complemented updated value is offered for the result register.
// ----------------------------------------------------------------------------
module crc32bs_core
  import crc32bs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crc32bs_step_t   step_i,
  output logic [CrcW-1:0] crc_o
);

  logic [CrcW-1:0] crc_q, crc_d, crc_upd;

  assign crc_upd = absorb_byte(crc_q, step_i.data);
  assign crc_o   = ~crc_upd;

  always_comb begin
    crc_d = crc_q;
    if (step_i.en) begin
      crc_d = step_i.last ? CrcInit : crc_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.en && step_i.last |=> crc_q == CrcInit)
    else $error("CRC register not cleared after closing byte");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i.en |=> $stable(crc_q))
    else $error("CRC register changed without a byte");

endmodule

// ===== src/crc32_byte_stream.sv =====
// ----------------------------------------------------------------------------
// crc32_byte_stream: byte-serial CRC-32 generator
// Stream in message bytes, stream out one CRC word per message.
// ----------------------------------------------------------------------------
// Each input beat carries one message byte, absorbed LSB first into a 32-bit
// Galois register with polynomial 0x04C11DB7 that starts from zero. The beat
// with s_axis_tlast high closes the message; one output beat then carries the
// complemented register and the register returns to zero. The block takes one
// byte per clock unless a closing byte is held up. Each byte is registered in
// the input register, the eight unrolled shift steps run between that register
// and the CRC register, and the result of a closing byte is registered in the
// output register. Only an output beat left waiting there holds up a closing byte.
module crc32_byte_stream
  import crc32bs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] data_byte
  input  logic            s_axis_tlast,   // last_byte
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [31:0]     m_axis_tdata    // [31:0] crc_value
);

  logic             in_valid_q, in_valid_d;
  logic             in_last_q;
  logic [ByteW-1:0] in_data_q;
  logic             out_valid_q, out_valid_d;
  logic [CrcW-1:0]  out_data_q;
  logic [CrcW-1:0]  crc_res;
  logic             out_free, advance, in_take;
  crc32bs_step_t    step;

  // A closing byte may only leave the input register when the result slot is
  // free or is being emptied in this same cycle.
  assign out_free = !out_valid_q || m_axis_tready;
  assign advance  = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take  = s_axis_tvalid && s_axis_tready;

  assign step.en   = advance;
  assign step.last = in_last_q;
  assign step.data = in_data_q;

  crc32bs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .crc_o  (crc_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      out_data_q <= crc_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> m_axis_tvalid && m_axis_tdata == $past(crc_res))
    else $error("Closing byte did not produce its result beat");

  a_byte_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q) && $stable(in_last_q))
    else $error("Held byte lost or changed in the input register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |-> !out_valid_q || m_axis_tready)
    else $error("Result beat overwritten before it was taken");

endmodule
